@@ hdl/spm_pkg.sv @@
package spm_pkg;

	// Default channel count of the multiplexer.
	localparam int NUM_CHANNELS_DEF = 8;

	// Configuration port address width: five 32-bit registers at 4*i.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_TICKS_PER_US = 3'd0;
	localparam logic [2:0] REG_SLOT_US      = 3'd1;
	localparam logic [2:0] REG_MIN_US       = 3'd2;
	localparam logic [2:0] REG_MAX_US       = 3'd3;
	localparam logic [2:0] REG_MID_US       = 3'd4;

	// Register reset values.
	localparam logic [4:0]  TICKS_PER_US_RST = 5'd20;
	localparam logic [12:0] SLOT_US_RST      = 13'd2500;
	localparam logic [11:0] MIN_US_RST       = 12'd1000;
	localparam logic [11:0] MAX_US_RST       = 12'd2000;
	localparam logic [11:0] MID_US_RST       = 12'd1500;

	// Stored width of every channel after reset, mid_us times ticks_per_us.
	localparam logic [15:0] WIDTH_RST = 16'(int'(MID_US_RST) * int'(TICKS_PER_US_RST));

	// Item modes.
	localparam logic [1:0] MODE_TICK      = 2'd0;
	localparam logic [1:0] MODE_SET_WIDTH = 2'd1;
	localparam logic [1:0] MODE_SET_EN    = 2'd2;

	// One input item.
	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  channel;
		logic [15:0] pulse_us;
		logic        enable;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] pins;
		logic [2:0] slot_channel;
	} out_item_t;

endpackage

@@ hdl/servo_pulse_multiplexer_core.sv @@
// A result enters the output register in the cycle after its item's transfer.
// Throughput: one item per cycle; an item is taken when the output register is empty
// or its result transfers in the same cycle, so a stalled result stops input.
// Reset (arst_n low) restores the register defaults, sets every channel width to
// mid_us times ticks_per_us, disables all channels and restarts at slot 0.
module servo_pulse_multiplexer_core #(
	parameter int NUM_CHANNELS = spm_pkg::NUM_CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  spm_pkg::in_item_t            item,
	output logic                         result_valid,
	input  logic                         result_ready,
	output spm_pkg::out_item_t           result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spm_pkg::PADDR_W-1:0]  paddr,
	input  logic [spm_pkg::PDATA_W-1:0]  pwdata,
	output logic [spm_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// Configuration registers.
	logic [4:0]  tpu_q;
	logic [12:0] slot_us_q;
	logic [11:0] min_us_q;
	logic [11:0] max_us_q;
	logic [11:0] mid_us_q;

	// Channel state.
	logic [15:0]       width_q [NUM_CHANNELS];
	logic              on_q    [NUM_CHANNELS];
	logic [SLOT_W-1:0] cur_q;
	logic [15:0]       cnt_q;
	logic [15:0]       lat_width_q;
	logic              lat_on_q;

	// Output register.
	logic               result_valid_q;
	spm_pkg::out_item_t result_q;

	logic              accept;
	logic              cfg_wr;
	logic [2:0]        reg_idx;
	logic [17:0]       slot_prod;
	logic [15:0]       slot_sat;
	logic [15:0]       slot_len;
	logic [16:0]       cnt_inc;
	logic              wrap;
	logic [SLOT_W-1:0] next_slot;
	logic [15:0]       us_lo;
	logic [15:0]       us_clamp;
	logic [16:0]       width_prod;
	logic [15:0]       width_new;
	logic              ch_ok;
	logic              pin_high;
	logic [31:0]       cur_ext;
	logic [7:0]        pins;

	// Handshakes.
	assign item_ready   = !result_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite;
	assign reg_idx      = paddr[4:2];

	// Register read-back.
	always_comb begin
		case (reg_idx)
			spm_pkg::REG_TICKS_PER_US: prdata = 32'(tpu_q);
			spm_pkg::REG_SLOT_US:      prdata = 32'(slot_us_q);
			spm_pkg::REG_MIN_US:       prdata = 32'(min_us_q);
			spm_pkg::REG_MAX_US:       prdata = 32'(max_us_q);
			spm_pkg::REG_MID_US:       prdata = 32'(mid_us_q);
			default:                   prdata = '0;
		endcase
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q     <= spm_pkg::TICKS_PER_US_RST;
			slot_us_q <= spm_pkg::SLOT_US_RST;
			min_us_q  <= spm_pkg::MIN_US_RST;
			max_us_q  <= spm_pkg::MAX_US_RST;
			mid_us_q  <= spm_pkg::MID_US_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				spm_pkg::REG_TICKS_PER_US: tpu_q     <= pwdata[4:0];
				spm_pkg::REG_SLOT_US:      slot_us_q <= pwdata[12:0];
				spm_pkg::REG_MIN_US:       min_us_q  <= pwdata[11:0];
				spm_pkg::REG_MAX_US:       max_us_q  <= pwdata[11:0];
				spm_pkg::REG_MID_US:       mid_us_q  <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// Slot length in ticks, saturated to 16 bits, never less than one tick.
	always_comb begin
		slot_prod = 18'(slot_us_q) * 18'(tpu_q);
		slot_sat  = (|slot_prod[17:16]) ? 16'hFFFF : slot_prod[15:0];
		slot_len  = (slot_sat == 16'd0) ? 16'd1 : slot_sat;
		cnt_inc   = {1'b0, cnt_q} + 17'd1;
		wrap      = cnt_inc >= {1'b0, slot_len};
		next_slot = (cur_q == SLOT_W'(NUM_CHANNELS - 1)) ? '0 : cur_q + SLOT_W'(1);
	end

	// Width clamp: raise to min_us, then lower to max_us, then scale to ticks.
	always_comb begin
		us_lo      = (item.pulse_us < 16'(min_us_q)) ? 16'(min_us_q) : item.pulse_us;
		us_clamp   = (us_lo > 16'(max_us_q)) ? 16'(max_us_q) : us_lo;
		width_prod = 17'(us_clamp[11:0]) * 17'(tpu_q);
		width_new  = width_prod[16] ? 16'hFFFF : width_prod[15:0];
		ch_ok      = 32'(item.channel) < NUM_CHANNELS;
	end

	// Pin levels of the state before this item.
	always_comb begin
		pin_high = lat_on_q && (cnt_q < lat_width_q);
		cur_ext  = 32'(cur_q);
		for (int i = 0; i < 8; i++) begin
			pins[i] = pin_high && (cur_ext == 32'(i));
		end
	end

	// Per-channel width and enable stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				width_q[i] <= spm_pkg::WIDTH_RST;
				on_q[i]    <= 1'b0;
			end
		end else if (accept && ch_ok) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (32'(item.channel) == 32'(i)) begin
					if (item.mode == spm_pkg::MODE_SET_WIDTH) begin
						width_q[i] <= width_new;
					end
					if (item.mode == spm_pkg::MODE_SET_EN) begin
						on_q[i] <= item.enable;
					end
				end
			end
		end
	end

	// Slot timer: count ticks, advance the slot and latch the next channel's settings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			cnt_q       <= '0;
			lat_width_q <= '0;
			lat_on_q    <= 1'b0;
		end else if (accept && item.mode == spm_pkg::MODE_TICK) begin
			if (wrap) begin
				cnt_q       <= '0;
				cur_q       <= next_slot;
				lat_width_q <= width_q[next_slot];
				lat_on_q    <= on_q[next_slot];
			end else begin
				cnt_q <= cnt_inc[15:0];
			end
		end
	end

	// Output register: every transfer in yields one result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.pins         <= pins;
			result_q.slot_channel <= cur_ext[2:0];
		end
	end

	// At most one pin is ever high.
	a_pins_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $onehot0(result_q.pins))
		else $error("more than one servo pin high");

	// The running slot always names an existing channel.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_q) < NUM_CHANNELS)
		else $error("slot index out of range");

	// A tick at the end of a slot restarts the counter.
	a_wrap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.mode == spm_pkg::MODE_TICK && wrap) |=> (cnt_q == 16'd0))
		else $error("slot counter not cleared at slot end");

	// A transfer in always leaves a result pending in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid_q)
		else $error("transfer did not produce a result");

endmodule

@@ test/servo_level_checker.sv @@
module servo_level_checker import spm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  in_item_t            item,
	input  logic                result_valid,
	input  logic                result_ready,
	input  out_item_t           result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic                pready,
	output int                  fail_count,
	output int                  pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = NUM_CHANNELS_DEF;

	// Shadow copy of the configuration registers.
	logic [4:0]  cfg_ticks_per_us;
	logic [12:0] cfg_slot_us;
	logic [11:0] cfg_min_us;
	logic [11:0] cfg_max_us;
	logic [11:0] cfg_mid_us;

	// Shadow copy of the channel table and the running slot.
	logic [15:0] width_tbl [NCH];
	logic        on_tbl [NCH];
	logic [2:0]  run_slot;
	logic [15:0] run_count;
	logic [15:0] held_width;
	logic        held_on;

	// Pin levels still owed by the block, oldest first.
	out_item_t   levels_due [$];
	int          mismatches;

	function automatic logic [15:0] clip16(input int unsigned v);
		return (v > 65535) ? 16'hFFFF : v[15:0];
	endfunction

	// Slot length in ticks; a zero product still gives a one-tick slot.
	function automatic logic [15:0] slot_ticks();
		logic [15:0] len;
		len = clip16(32'(cfg_slot_us) * 32'(cfg_ticks_per_us));
		return (len == 16'd0) ? 16'd1 : len;
	endfunction

	// Output levels as the state stands before the item acts on it.
	function automatic out_item_t levels_now();
		out_item_t r;
		r.pins = '0;
		if (held_on && (run_count < held_width))
			r.pins[run_slot] = 1'b1;
		r.slot_channel = run_slot;
		return r;
	endfunction

	// Advance the shadow state by one input item.
	task automatic servo_step(input in_item_t it);
		int unsigned us;
		case (it.mode)
			MODE_TICK: begin
				run_count = run_count + 16'd1;
				if (run_count >= slot_ticks()) begin
					run_count = '0;
					run_slot = (int'(run_slot) == NCH - 1) ? 3'd0 : run_slot + 3'd1;
					held_width = width_tbl[run_slot];
					held_on = on_tbl[run_slot];
				end
			end
			MODE_SET_WIDTH: begin
				if (int'(it.channel) < NCH) begin
					us = 32'(it.pulse_us);
					if (us < 32'(cfg_min_us))
						us = 32'(cfg_min_us);
					if (us > 32'(cfg_max_us))
						us = 32'(cfg_max_us);
					width_tbl[it.channel] = clip16(us * 32'(cfg_ticks_per_us));
				end
			end
			MODE_SET_EN: begin
				if (int'(it.channel) < NCH)
					on_tbl[it.channel] = it.enable;
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		fail_count = mismatches;
		if (mismatches <= 100)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Watch all three ports. A result transfer is matched before the item of the
	// same edge is predicted, since it always belongs to an older item.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			cfg_ticks_per_us = TICKS_PER_US_RST;
			cfg_slot_us = SLOT_US_RST;
			cfg_min_us = MIN_US_RST;
			cfg_max_us = MAX_US_RST;
			cfg_mid_us = MID_US_RST;
			for (int i = 0; i < NCH; i++) begin
				width_tbl[i] = WIDTH_RST;
				on_tbl[i] = 1'b0;
			end
			run_slot = '0;
			run_count = '0;
			held_width = '0;
			held_on = 1'b0;
			levels_due.delete();
			mismatches = 0;
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_TICKS_PER_US: cfg_ticks_per_us = pwdata[4:0];
					REG_SLOT_US:      cfg_slot_us = pwdata[12:0];
					REG_MIN_US:       cfg_min_us = pwdata[11:0];
					REG_MAX_US:       cfg_max_us = pwdata[11:0];
					REG_MID_US:       cfg_mid_us = pwdata[11:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (levels_due.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: pins=%h slot=%0d",
						result.pins, result.slot_channel));
				end else begin
					want = levels_due.pop_front();
					if (result.pins !== want.pins)
						report_mismatch($sformatf("pins %h, predicted %h",
							result.pins, want.pins));
					if (result.slot_channel !== want.slot_channel)
						report_mismatch($sformatf("slot_channel %0d, predicted %0d",
							result.slot_channel, want.slot_channel));
				end
			end
			if (item_valid && item_ready) begin
				levels_due.push_back(levels_now());
				servo_step(item);
			end
			pending_count = levels_due.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spm_pkg::*;

	// The one mode value the block must leave without effect.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	in_item_t            item;
	logic                result_valid;
	logic                result_ready = 1'b0;
	out_item_t           result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int fail_count;
	int pending_count;

	// Pacing controls for the sender and the receiver.
	bit steady_tx = 1'b0;
	bit steady_rx = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always #2 clk = ~clk;

	servo_pulse_multiplexer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	servo_level_checker u_level_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Receiver: random stalls, a steady stretch, and a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 60;
			result_ready <= 1'b0;
		end else if (steady_rx) begin
			result_ready <= 1'b1;
		end else begin
			result_ready <= ($urandom_range(99) >= 24);
		end
	end

	function automatic in_item_t make_item(input logic [1:0] mode, input int ch, input int us,
		input bit en);
		in_item_t x;
		x.mode = mode;
		x.channel = ch[2:0];
		x.pulse_us = us[15:0];
		x.enable = en;
		return x;
	endfunction

	// Mostly ticks so slots turn over; writes carry a mix of small and full-range widths.
	function automatic in_item_t random_item();
		in_item_t x;
		int pick;
		x.channel = 3'($urandom_range(7));
		x.pulse_us = 16'($urandom_range(65535));
		x.enable = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 60) begin
			x.mode = MODE_TICK;
		end else if (pick < 80) begin
			x.mode = MODE_SET_WIDTH;
			case ($urandom_range(3))
				0: x.pulse_us = 16'($urandom_range(8));
				1: x.pulse_us = 16'($urandom_range(4100, 4090));
				default: ;
			endcase
		end else if (pick < 95) begin
			x.mode = MODE_SET_EN;
			x.enable = ($urandom_range(9) < 7);
		end else begin
			x.mode = MODE_UNUSED;
		end
		return x;
	endfunction

	// Offer one item and hold it until the transfer; returns at a falling edge.
	task automatic send_item(input in_item_t x);
		while (!steady_tx && ($urandom_range(99) < 24)) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted result has come out.
	task automatic settle_block();
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// One register write; unused upper data bits carry random noise.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] field,
		input logic [31:0] mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= ($urandom & ~mask) | (field & mask);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic program_regs(input int tpu, input int slot, input int lo, input int hi,
		input int mid);
		settle_block();
		write_reg(REG_TICKS_PER_US, tpu, 32'h1F);
		write_reg(REG_SLOT_US, slot, 32'h1FFF);
		write_reg(REG_MIN_US, lo, 32'hFFF);
		write_reg(REG_MAX_US, hi, 32'hFFF);
		write_reg(REG_MID_US, mid, 32'hFFF);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_run(input int count);
		for (int n = 0; n < count; n++)
			send_item(random_item());
	endtask

	// Stimulus: directed items, then random phases under several register settings.
	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: idle first slot, clamping to both bounds, unused mode.
		send_item(make_item(MODE_TICK, 0, 0, 0));
		send_item(make_item(MODE_UNUSED, 5, 65535, 1));
		send_item(make_item(MODE_SET_WIDTH, 0, 0, 0));
		send_item(make_item(MODE_SET_WIDTH, 7, 65535, 1));
		send_item(make_item(MODE_SET_EN, 0, 0, 1));
		send_item(make_item(MODE_SET_EN, 7, 0, 1));
		send_item(make_item(MODE_TICK, 3, 65535, 1));

		// Three-tick slots: short pulse, pulse equal to and beyond the slot, disabled channel.
		program_regs(1, 3, 0, 5, 4095);
		send_item(make_item(MODE_SET_WIDTH, 1, 1, 0));
		send_item(make_item(MODE_SET_WIDTH, 2, 5, 0));
		send_item(make_item(MODE_SET_WIDTH, 3, 3, 0));
		send_item(make_item(MODE_SET_EN, 1, 0, 1));
		send_item(make_item(MODE_SET_EN, 2, 0, 1));
		send_item(make_item(MODE_SET_EN, 3, 0, 1));
		send_item(make_item(MODE_SET_EN, 0, 0, 0));
		repeat (10) send_item(make_item(MODE_TICK, 0, 0, 0));

		random_run(150);

		// One-tick slots with min above max.
		program_regs(31, 0, 4095, 0, 0);
		random_run(60);

		// Four-tick slots; the receiver holds off long enough to back the block up.
		program_regs(2, 2, 1, 3, 1500);
		for (int n = 0; n < 150; n++) begin
			if (n == 40)
				hold_req++;
			send_item(random_item());
		end

		// Saturated slot length and saturated widths.
		program_regs(31, 8191, 4095, 4095, 0);
		random_run(50);

		// Zero ticks per microsecond.
		program_regs(0, 100, 0, 4095, 2047);
		random_run(40);

		// One-tick slots, starting with a stretch where neither side idles.
		program_regs(1, 1, 0, 4095, 4095);
		steady_tx = 1'b1;
		steady_rx = 1'b1;
		for (int n = 0; n < 150; n++) begin
			if (n == 60) begin
				steady_tx = 1'b0;
				steady_rx = 1'b0;
			end
			send_item(random_item());
		end

		settle_block();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#500000;
		$display("FAIL");
		$finish;
	end

endmodule
